>>> rtl/core/rwl_pkg.sv
// Shared types and constants for the reader/writer lock arbiter.
// Used by the controller, datapath, queue and top-level modules.
`timescale 1ns / 1ps

package rwl_pkg;

  localparam int TID_W   = 4;
  localparam int NUM_IDS = 1 << TID_W;
  localparam int RC_W    = 5;
  localparam logic [RC_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_UNLOCK = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_GRANTED    = 3'd0,
    STAT_QUEUED     = 3'd1,
    STAT_RELEASED   = 3'd2,
    STAT_NOT_HOLDER = 3'd3,
    STAT_IDLE       = 3'd4,
    STAT_BUSY       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted request
    logic exec;   // carry out the captured request
    logic drain;  // grant and report the head waiting reader
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // the result register can take a result this cycle
    logic wake_rd;     // the captured request releases the writer onto waiting readers
    logic drain_last;  // exactly one reader is left in the reader queue
  } dp_status_t;

endpackage

>>> rtl/core/reader_writer_lock_arbiter.sv
// Writer-preferring reader/writer lock arbiter, top level.
// Depends on rwl_pkg, rwl_ctrl and rwl_datapath (which holds two rwl_fifo queues).
`timescale 1ns / 1ps

// A request is taken in S_IDLE and carried out in S_EXEC, which waits while the result
// register holds a stalled result. An unlock by the holding writer that wakes N queued
// readers first releases the lock and then reports the readers, one per cycle while the
// result register can take them, because the reader queue memory gives up one head entry
// per cycle. Both queues hold THREADS entries; their memories need no clearing after
// reset, and the block takes requests as soon as reset is released.
module reader_writer_lock_arbiter #(
  parameter int THREADS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic [rwl_pkg::TID_W-1:0] thread_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                status,
  output logic                      woken_valid,
  output logic [rwl_pkg::TID_W-1:0] woken_thread,
  output logic                      last
);
  import rwl_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t dps;

  rwl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .ctl(ctl), .dps(dps)
  );

  rwl_datapath #(.THREADS(THREADS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .dps(dps), .cmd(cmd), .thread_id(thread_id),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .woken_valid(woken_valid), .woken_thread(woken_thread), .last(last)
  );

endmodule

>>> rtl/core/rwl_fifo.sv
// Wait queue: a circular FIFO of thread ids in a memory, plus a membership mask.
// Depends on rwl_pkg for the thread id width.
`timescale 1ns / 1ps

module rwl_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      pop,
  input  logic [rwl_pkg::TID_W-1:0] push_id,
  input  logic [rwl_pkg::TID_W-1:0] query_id,
  output logic [rwl_pkg::TID_W-1:0] head_id,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                      dup
);
  import rwl_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [TID_W-1:0]   mem [DEPTH];
  logic [PW-1:0]      head;
  logic [PW-1:0]      head_next;
  logic [PW-1:0]      tail;
  logic [CW-1:0]      cnt;
  logic [NUM_IDS-1:0] mask;
  logic [TID_W-1:0]   head_rd;

  always_comb begin
    head_next = head;
    if (pop) begin
      head_next = (head == LAST_PTR) ? '0 : head + PW'(1);
    end
  end

  // Reads look one pop ahead, so head_rd tracks the head except on a push to empty.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_id;
    end
    head_rd <= mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
      mask <= '0;
    end else begin
      head <= head_next;
      if (push) begin
        tail          <= (tail == LAST_PTR) ? '0 : tail + PW'(1);
        cnt           <= cnt + CW'(1);
        mask[push_id] <= 1'b1;
      end else if (pop) begin
        cnt           <= cnt - CW'(1);
        mask[head_rd] <= 1'b0;
      end
    end
  end

  assign head_id = head_rd;
  assign count   = cnt;
  assign dup     = mask[query_id];

endmodule

>>> rtl/core/rwl_datapath.sv
// Datapath: lock state, the two wait queues and the result register.
// Depends on rwl_pkg and rwl_fifo; driven by commands from rwl_ctrl.
`timescale 1ns / 1ps

module rwl_datapath #(
  parameter int THREADS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rwl_pkg::ctrl_cmd_t        ctl,
  output rwl_pkg::dp_status_t       dps,
  input  logic [1:0]                cmd,
  input  logic [rwl_pkg::TID_W-1:0] thread_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                status,
  output logic                      woken_valid,
  output logic [rwl_pkg::TID_W-1:0] woken_thread,
  output logic                      last
);
  import rwl_pkg::*;

  localparam int CW = $clog2(THREADS+1);
  localparam logic [CW-1:0] FULL_CNT = CW'(THREADS);

  cmd_t             cmd_q;
  logic [TID_W-1:0] tid_q;

  logic [RC_W-1:0]  reader_count, reader_count_next;
  logic             writer_held, writer_held_next;
  logic [TID_W-1:0] writer_holder, writer_holder_next;

  logic             rq_push, rq_pop, wq_push, wq_pop;
  logic [TID_W-1:0] rq_head, wq_head;
  logic [CW-1:0]    rq_cnt, wq_cnt;
  logic             rq_dup, wq_dup;

  logic             emit;
  status_t          e_status;
  logic             e_woken;
  logic [TID_W-1:0] e_thread;
  logic             e_last;

  status_t          status_q;
  logic             holder_match;

  rwl_fifo #(.DEPTH(THREADS)) u_rq (
    .clk(clk), .rst(rst), .push(rq_push), .pop(rq_pop), .push_id(tid_q),
    .query_id(tid_q), .head_id(rq_head), .count(rq_cnt), .dup(rq_dup)
  );

  rwl_fifo #(.DEPTH(THREADS)) u_wq (
    .clk(clk), .rst(rst), .push(wq_push), .pop(wq_pop), .push_id(tid_q),
    .query_id(tid_q), .head_id(wq_head), .count(wq_cnt), .dup(wq_dup)
  );

  assign holder_match = writer_held && (writer_holder == tid_q);

  assign dps.out_free   = !out_valid || !out_stall;
  assign dps.wake_rd    = (cmd_q == CMD_UNLOCK) && holder_match &&
                          (wq_cnt == '0) && (rq_cnt != '0);
  assign dps.drain_last = (rq_cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd_t'(cmd);
      tid_q <= thread_id;
    end
  end

  always_comb begin
    reader_count_next  = reader_count;
    writer_held_next   = writer_held;
    writer_holder_next = writer_holder;
    rq_push  = 1'b0;
    rq_pop   = 1'b0;
    wq_push  = 1'b0;
    wq_pop   = 1'b0;
    emit     = 1'b0;
    e_status = STAT_GRANTED;
    e_woken  = 1'b0;
    e_thread = '0;
    e_last   = 1'b1;

    if (ctl.drain) begin
      rq_pop   = 1'b1;
      emit     = 1'b1;
      e_status = STAT_RELEASED;
      e_woken  = 1'b1;
      e_thread = rq_head;
      e_last   = dps.drain_last;
      if (reader_count != COUNT_MAX) begin
        reader_count_next = reader_count + RC_W'(1);
      end
    end else if (ctl.exec) begin
      case (cmd_q)
        CMD_READ: begin
          emit = 1'b1;
          if (writer_held || wq_cnt != '0) begin
            if (rq_dup) begin
              e_status = STAT_QUEUED;
            end else if (rq_cnt == FULL_CNT) begin
              e_status = STAT_BUSY;
            end else begin
              rq_push  = 1'b1;
              e_status = STAT_QUEUED;
            end
          end else begin
            e_status = STAT_GRANTED;
            if (reader_count != COUNT_MAX) begin
              reader_count_next = reader_count + RC_W'(1);
            end
          end
        end
        CMD_WRITE: begin
          emit = 1'b1;
          if (writer_held || reader_count != '0) begin
            if (wq_dup) begin
              e_status = STAT_QUEUED;
            end else if (wq_cnt == FULL_CNT) begin
              e_status = STAT_BUSY;
            end else begin
              wq_push  = 1'b1;
              e_status = STAT_QUEUED;
            end
          end else begin
            writer_held_next   = 1'b1;
            writer_holder_next = tid_q;
            e_status           = STAT_GRANTED;
          end
        end
        CMD_UNLOCK: begin
          e_status = STAT_RELEASED;
          if (holder_match) begin
            writer_held_next   = 1'b0;
            writer_holder_next = '0;
            if (wq_cnt != '0) begin
              wq_pop             = 1'b1;
              writer_held_next   = 1'b1;
              writer_holder_next = wq_head;
              emit               = 1'b1;
              e_woken            = 1'b1;
              e_thread           = wq_head;
            end else begin
              // With readers waiting, the results come from the drain steps.
              emit = (rq_cnt == '0);
            end
          end else if (reader_count != '0) begin
            reader_count_next = reader_count - RC_W'(1);
            emit              = 1'b1;
            if (reader_count == RC_W'(1) && wq_cnt != '0) begin
              wq_pop             = 1'b1;
              writer_held_next   = 1'b1;
              writer_holder_next = wq_head;
              e_woken            = 1'b1;
              e_thread           = wq_head;
            end
          end else begin
            emit     = 1'b1;
            e_status = STAT_NOT_HOLDER;
          end
        end
        CMD_CHECK: begin
          emit     = 1'b1;
          e_status = (reader_count != '0 || writer_held || rq_cnt != '0 || wq_cnt != '0) ?
                     STAT_BUSY : STAT_IDLE;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reader_count  <= '0;
      writer_held   <= 1'b0;
      writer_holder <= '0;
      out_valid     <= 1'b0;
    end else begin
      reader_count  <= reader_count_next;
      writer_held   <= writer_held_next;
      writer_holder <= writer_holder_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_q     <= e_status;
      woken_valid  <= e_woken;
      woken_thread <= e_thread;
      last         <= e_last;
    end
  end

  assign status = status_q;

endmodule

>>> rtl/core/rwl_ctrl.sv
// Controller state machine: accepts requests and sequences execute and reader drain.
// Depends on rwl_pkg for the state and command/status types.
`timescale 1ns / 1ps

module rwl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output rwl_pkg::ctrl_cmd_t  ctl,
  input  rwl_pkg::dp_status_t dps
);
  import rwl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // Wait until the result register can take whatever this transaction produces.
        if (dps.out_free) begin
          ctl.exec   = 1'b1;
          state_next = dps.wake_rd ? S_WAKE : S_IDLE;
        end
      end
      S_WAKE: begin
        if (dps.out_free) begin
          ctl.drain = 1'b1;
          if (dps.drain_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/rwl_checker.sv
// Port-level checks for the reader/writer lock arbiter, and the bind that attaches them.
// Depends on rwl_pkg for the status codes.
`timescale 1ns / 1ps

module rwl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [2:0]                status,
  input logic                      woken_valid,
  input logic [rwl_pkg::TID_W-1:0] woken_thread,
  input logic                      last
);
  import rwl_pkg::*;

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(woken_valid) &&
    $stable(woken_thread) && $stable(last))
    else $error("stalled result changed");

  // Only a release can name a woken thread.
  a_woken_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && woken_valid |-> status == STAT_RELEASED)
    else $error("woken thread reported with a status other than released");

  // A result that wakes nobody always ends its request.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !woken_valid |-> last)
    else $error("non-wake result without last");

  // The block never accepts a request while a multi-result wake is still being reported.
  a_no_accept_mid_wake: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |-> in_stall)
    else $error("request accepted in the middle of a reader wake");

endmodule

bind reader_writer_lock_arbiter rwl_checker u_rwl_checker (.*);
